// ===== rtl/char_lcd_nibble_fifo_driver_unit_defines.svh =====
// Assertion macros shared by the character-LCD nibble driver RTL.
`ifndef CHAR_LCD_NIBBLE_FIFO_DRIVER_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_FIFO_DRIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define CLNFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define CLNFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clnfd_pkg.sv =====
// Types, codes and the microcode program of the character-LCD nibble driver.
`timescale 1ns / 1ps
`default_nettype none

package clnfd_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CHAR   = 2'd1;
  localparam logic [1:0] CMD_RAW    = 2'd2;
  localparam logic [1:0] CMD_CURSOR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_OFFSET  = 2'd2;

  // Send phases of one word on the 4-bit bus.
  localparam logic [1:0] PH_HIGH      = 2'd0;
  localparam logic [1:0] PH_HIGH_DROP = 2'd1;
  localparam logic [1:0] PH_LOW       = 2'd2;
  localparam logic [1:0] PH_LOW_DROP  = 2'd3;

  // Sequencer steps. The kind steps sit at STEP_KIND_BASE plus the kind code.
  localparam logic [2:0] STEP_FETCH     = 3'd0;
  localparam logic [2:0] STEP_KIND_BASE = 3'd1;
  localparam logic [2:0] STEP_TICK_RD   = 3'd1;
  localparam logic [2:0] STEP_CHAR      = 3'd2;
  localparam logic [2:0] STEP_RAW       = 3'd3;
  localparam logic [2:0] STEP_CURSOR    = 3'd4;
  localparam logic [2:0] STEP_TICK      = 3'd5;
  localparam logic [2:0] STEP_PUSH      = 3'd6;
  localparam logic [2:0] STEP_DONE      = 3'd7;

  // Datapath operations.
  localparam logic [2:0] OP_LATCH  = 3'd0;
  localparam logic [2:0] OP_NOP    = 3'd1;
  localparam logic [2:0] OP_CHAR   = 3'd2;
  localparam logic [2:0] OP_RAW    = 3'd3;
  localparam logic [2:0] OP_CURSOR = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;
  localparam logic [2:0] OP_PUSH   = 3'd6;
  localparam logic [2:0] OP_RESULT = 3'd7;

  // Sequencing conditions.
  localparam logic [1:0] COND_FETCH    = 2'd0;
  localparam logic [1:0] COND_ALWAYS   = 2'd1;
  localparam logic [1:0] COND_RANGE    = 2'd2;
  localparam logic [1:0] COND_OUT_FREE = 2'd3;

  localparam int unsigned BOOT_COUNT = 7;
  localparam int unsigned BOOT_IDX_W = 3;

  typedef logic [8:0] lcd_word_t;

  typedef struct packed {
    logic [2:0] nxt;
    logic [2:0] jmp;
    logic [1:0] cond;
    logic [2:0] op;
  } ctrl_word_t;

  // Start-up words sitting in the queue after reset.
  function automatic lcd_word_t boot_word(input logic [BOOT_IDX_W-1:0] idx);
    lcd_word_t w;
    w = 9'h000;
    case (idx)
      3'd0:    w = 9'h033;
      3'd1:    w = 9'h032;
      3'd2:    w = 9'h028;
      3'd3:    w = 9'h00C;
      3'd4:    w = 9'h006;
      3'd5:    w = 9'h001;
      3'd6:    w = 9'h00E;
      default: w = 9'h000;
    endcase
    return w;
  endfunction

  // Microcode program: one control word per step.
  function automatic ctrl_word_t ucode(input logic [2:0] step);
    ctrl_word_t c;
    c = '{nxt: STEP_FETCH, jmp: STEP_FETCH, cond: COND_ALWAYS, op: OP_NOP};
    unique case (step)
      STEP_FETCH:   c = '{nxt: STEP_FETCH, jmp: STEP_FETCH, cond: COND_FETCH,
                          op: OP_LATCH};
      STEP_TICK_RD: c = '{nxt: STEP_TICK, jmp: STEP_TICK, cond: COND_ALWAYS,
                          op: OP_NOP};
      STEP_CHAR:    c = '{nxt: STEP_PUSH, jmp: STEP_PUSH, cond: COND_ALWAYS,
                          op: OP_CHAR};
      STEP_RAW:     c = '{nxt: STEP_PUSH, jmp: STEP_PUSH, cond: COND_ALWAYS,
                          op: OP_RAW};
      STEP_CURSOR:  c = '{nxt: STEP_PUSH, jmp: STEP_DONE, cond: COND_RANGE,
                          op: OP_CURSOR};
      STEP_TICK:    c = '{nxt: STEP_DONE, jmp: STEP_DONE, cond: COND_ALWAYS,
                          op: OP_TICK};
      STEP_PUSH:    c = '{nxt: STEP_DONE, jmp: STEP_DONE, cond: COND_ALWAYS,
                          op: OP_PUSH};
      STEP_DONE:    c = '{nxt: STEP_FETCH, jmp: STEP_FETCH, cond: COND_OUT_FREE,
                          op: OP_RESULT};
      default:      c = '{nxt: STEP_FETCH, jmp: STEP_FETCH, cond: COND_ALWAYS,
                          op: OP_NOP};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/char_lcd_nibble_fifo_driver_unit.sv =====
// Character-LCD 4-bit interface: word queue, microcoded sequencer and pin driver.
`timescale 1ns / 1ps
`default_nettype none

// This block feeds a character LCD over a 4-bit bus. Words of nine bits (an RS
// flag above a byte) wait in a ring queue of QUEUE_DEPTH entries that already
// holds the seven start-up words after reset. Each input word is one request:
// a service tick moves the pin sequence one phase further (high nibble with E
// up, E down, low nibble with E up, E down and pop), a character or command
// write pushes one word, and a cursor move checks the position against the
// display size and pushes the DDRAM address command. Each request gives one
// result word with a status, the pin levels now driven and the queue fill.
// A microcoded sequencer runs the work, one control word per cycle: from the
// fetch step a request goes to the step for its kind, a write or an in-range
// cursor move then passes the push step, and the done step loads the result
// word into the output register. An out-of-range cursor move skips the push
// step. The tick path spends one of its steps on the registered read of the
// queue memory. The result sits in an output register, so the sequencer
// fetches the next request while it waits; it stalls only when a second
// result is ready before the first has been taken.
module char_lcd_nibble_fifo_driver_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input words.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Lowest bit up: data_byte[7:0], cursor_column[15:8], cursor_row[23:16].
  input  wire logic [23:0]            in_tdata,
  // command[1:0].
  input  wire logic [1:0]             in_tuser,
  // Result words.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // Lowest bit up: status[1:0], pin_rs[2], pin_data[6:3], pin_enable[7],
  // words_pending starting at bit 8, zero fill to a whole byte.
  output logic [((8 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata,
  // Configuration writes.
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [6:0]             cfg_wdata
);

  import clnfd_pkg::*;

  localparam int unsigned PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OUT_BITS = 8 + CNT_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Queue storage. Entries that were never written are never popped.
  lcd_word_t mem [QUEUE_DEPTH];

  // Sequencer.
  logic [2:0]       step_r, step_nxt;
  ctrl_word_t       uc;

  // Latched request and staged word.
  logic [7:0]       byte_r, byte_nxt;
  logic [7:0]       col_r, col_nxt;
  logic [7:0]       row_r, row_nxt;
  lcd_word_t        stage_r, stage_nxt;
  logic [1:0]       status_r, status_nxt;

  // Queue control.
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BOOT_COUNT-1:0] boot_vld_r, boot_vld_nxt;
  logic             wr_en;

  // Registered read of the head word.
  lcd_word_t        mem_rd_r;
  lcd_word_t        boot_word_r;
  logic             boot_sel_r;
  lcd_word_t        head_word;

  // Pins and send phase.
  logic [1:0]       phase_r, phase_nxt;
  logic             rs_r, rs_nxt;
  logic [3:0]       data_r, data_nxt;
  logic             en_r, en_nxt;

  // Configuration.
  logic [6:0]       cols_r;
  logic [2:0]       rows_r;
  logic [6:0]       offset_r;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic             in_fire;
  logic             out_free;
  logic             cur_bad;
  logic [7:0]       cur_addr;
  logic             q_full;

  assign uc        = ucode(step_r);
  assign in_tready = (step_r == STEP_FETCH);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign q_full    = (count_r == CNT_W'(QUEUE_DEPTH));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A cursor move is out of range when either coordinate reaches its limit;
  // a zero limit therefore rejects every move.
  assign cur_bad  = (col_r >= {1'b0, cols_r}) || (row_r >= {5'b0, rows_r});
  assign cur_addr = col_r + ((row_r == 8'd1) ? {1'b0, offset_r} : 8'd0);

  assign head_word = boot_sel_r ? boot_word_r : mem_rd_r;

  // Next step of the program.
  always_comb begin
    step_nxt = step_r;
    unique case (uc.cond)
      COND_FETCH: begin
        if (in_fire) begin
          step_nxt = STEP_KIND_BASE + {1'b0, in_tuser};
        end
      end
      COND_ALWAYS:   step_nxt = uc.nxt;
      COND_RANGE:    step_nxt = cur_bad ? uc.jmp : uc.nxt;
      COND_OUT_FREE: step_nxt = out_free ? uc.nxt : step_r;
      default:       step_nxt = uc.nxt;
    endcase
  end

  // Datapath driven by the current control word.
  always_comb begin
    byte_nxt      = byte_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    stage_nxt     = stage_r;
    status_nxt    = status_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    boot_vld_nxt  = boot_vld_r;
    wr_en         = 1'b0;
    phase_nxt     = phase_r;
    rs_nxt        = rs_r;
    data_nxt      = data_r;
    en_nxt        = en_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (uc.op)
      OP_LATCH: begin
        if (in_fire) begin
          byte_nxt   = in_tdata[7:0];
          col_nxt    = in_tdata[15:8];
          row_nxt    = in_tdata[23:16];
          status_nxt = ST_OK;
        end
      end
      OP_NOP: begin
      end
      OP_CHAR: stage_nxt = {1'b1, byte_r};
      OP_RAW:  stage_nxt = {1'b0, byte_r};
      OP_CURSOR: begin
        if (cur_bad) begin
          status_nxt = ST_RANGE;
        end else begin
          stage_nxt = {2'b01, cur_addr[6:0]};
        end
      end
      OP_TICK: begin
        unique case (phase_r)
          PH_HIGH: begin
            // The sequence only starts on a queued word.
            if (count_r != '0) begin
              rs_nxt    = head_word[8];
              data_nxt  = head_word[7:4];
              en_nxt    = 1'b1;
              phase_nxt = PH_HIGH_DROP;
            end
          end
          PH_HIGH_DROP: begin
            en_nxt    = 1'b0;
            phase_nxt = PH_LOW;
          end
          PH_LOW: begin
            data_nxt  = head_word[3:0];
            en_nxt    = 1'b1;
            phase_nxt = PH_LOW_DROP;
          end
          default: begin
            en_nxt = 1'b0;
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
            rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
            phase_nxt  = PH_HIGH;
          end
        endcase
      end
      OP_PUSH: begin
        if (q_full) begin
          status_nxt = ST_BUSY;
        end else begin
          wr_en      = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
          count_nxt  = count_r + 1'b1;
          // Overwriting a start-up slot retires its constant.
          if (wr_ptr_r < PTR_W'(BOOT_COUNT)) begin
            boot_vld_nxt[wr_ptr_r[BOOT_IDX_W-1:0]] = 1'b0;
          end
        end
      end
      OP_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({count_r, en_r, data_r, rs_r, status_r});
        end
      end
      default: begin
      end
    endcase
  end

  // Queue memory: one write port, one registered read at the head pointer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= stage_r;
    end
    mem_rd_r    <= mem[rd_ptr_r];
    boot_word_r <= boot_word(rd_ptr_r[BOOT_IDX_W-1:0]);
    boot_sel_r  <= (rd_ptr_r < PTR_W'(BOOT_COUNT)) && boot_vld_r[rd_ptr_r[BOOT_IDX_W-1:0]];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    stage_r    <= stage_nxt;
    out_data_r <= out_data_nxt;
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_FETCH;
      status_r    <= ST_OK;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= PTR_W'(BOOT_COUNT);
      count_r     <= CNT_W'(BOOT_COUNT);
      boot_vld_r  <= '1;
      phase_r     <= PH_HIGH;
      rs_r        <= 1'b0;
      data_r      <= 4'd0;
      en_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cols_r      <= 7'd16;
      rows_r      <= 3'd2;
      offset_r    <= 7'd64;
    end else begin
      step_r      <= step_nxt;
      status_r    <= status_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      boot_vld_r  <= boot_vld_nxt;
      phase_r     <= phase_nxt;
      rs_r        <= rs_nxt;
      data_r      <= data_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS: cols_r   <= cfg_wdata;
          REG_ROWS:    rows_r   <= cfg_wdata[2:0];
          REG_OFFSET:  offset_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

`include "char_lcd_nibble_fifo_driver_unit_defines.svh"

  `CLNFD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `CLNFD_ASSERT_NOW(a_phase_needs_word, phase_r != PH_HIGH, count_r != '0, "send phase on empty queue")
  `CLNFD_ASSERT_NOW(a_enable_phase, 1'b1, en_r == phase_r[0], "E level out of step with phase")
  `CLNFD_ASSERT_NOW(a_empty_ptrs, count_r == '0, wr_ptr_r == rd_ptr_r, "empty queue with split pointers")
  `CLNFD_ASSERT_NEXT(a_accept_leaves_fetch, in_fire, step_r != STEP_FETCH, "accepted word not dispatched")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the character-LCD nibble FIFO driver.
`timescale 1ns / 1ps

module tb;
  import clnfd_pkg::*;

  localparam int unsigned LCD_DEPTH = 16;
  localparam int unsigned OUT_W = ((8 + $clog2(LCD_DEPTH + 1) + 7) / 8) * 8;
  localparam int unsigned GAP_PCT = 29;
  localparam int unsigned BLOCK_ITEMS = 150;
  localparam int unsigned BLOCKS = 12;

  // One request word as the host sees it.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] cursor_column;
    logic [7:0] cursor_row;
  } lcd_request_t;

  // One result word, field by field.
  typedef struct packed {
    logic [1:0] status;
    logic       pin_rs;
    logic [3:0] pin_data;
    logic       pin_enable;
    logic [4:0] words_pending;
  } lcd_response_t;

  // Clock, reset and every block input start at known levels.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = CMD_TICK;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_COLUMNS;
  logic [6:0] cfg_wdata = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  char_lcd_nibble_fifo_driver_unit #(
    .QUEUE_DEPTH(LCD_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Shadow copy of the display interface. It mirrors the word ring, the
  // nibble send sequence, the pin levels and the three display registers,
  // and is advanced once for every request word the block accepts.
  // ---------------------------------------------------------------------
  logic [8:0] ring_words [LCD_DEPTH];
  int unsigned ring_fill;
  logic [3:0] pop_slot;
  logic [3:0] push_slot;
  logic [1:0] nibble_phase;
  logic rs_pin;
  logic [3:0] data_pins;
  logic enable_pin;
  logic [6:0] column_limit;
  logic [2:0] row_limit;
  logic [6:0] line2_offset;

  // Words the block is expected to send back, oldest first.
  lcd_response_t pending_responses[$];
  // Request words waiting to be offered on the input side.
  lcd_request_t request_queue[$];

  // Turns the random gaps off on both sides for one whole block.
  bit steady_flow = 1'b0;

  int unsigned errors = 0;
  int unsigned requests_taken = 0;
  int unsigned responses_seen = 0;
  int unsigned status_tally [4];
  int unsigned idle_ticks = 0;
  int unsigned peak_fill = 0;

  task automatic reset_shadow();
    for (int i = 0; i < LCD_DEPTH; i++) ring_words[i] = 9'h000;
    // Power-up init sequence that the block queues on its own.
    ring_words[0] = 9'h033;
    ring_words[1] = 9'h032;
    ring_words[2] = 9'h028;
    ring_words[3] = 9'h00C;
    ring_words[4] = 9'h006;
    ring_words[5] = 9'h001;
    ring_words[6] = 9'h00E;
    ring_fill = 7;
    pop_slot = '0;
    push_slot = 4'd7;
    nibble_phase = PH_HIGH;
    rs_pin = 1'b0;
    data_pins = 4'h0;
    enable_pin = 1'b0;
    column_limit = 7'd16;
    row_limit = 3'd2;
    line2_offset = 7'd64;
  endtask

  function automatic logic [1:0] queue_lcd_word(input logic [8:0] w);
    if (ring_fill >= LCD_DEPTH) return ST_BUSY;
    ring_words[push_slot] = w;
    push_slot = push_slot + 4'd1;
    ring_fill++;
    return ST_OK;
  endfunction

  // One step of the bus sequencer: E rises with each nibble and the word
  // leaves the ring when E drops after the low nibble.
  task automatic advance_bus();
    logic [8:0] head;
    head = ring_words[pop_slot];
    case (nibble_phase)
      PH_HIGH: begin
        if (ring_fill != 0) begin
          rs_pin = head[8];
          data_pins = head[7:4];
          enable_pin = 1'b1;
          nibble_phase = PH_HIGH_DROP;
        end else begin
          idle_ticks++;
        end
      end
      PH_HIGH_DROP: begin
        enable_pin = 1'b0;
        nibble_phase = PH_LOW;
      end
      PH_LOW: begin
        data_pins = head[3:0];
        enable_pin = 1'b1;
        nibble_phase = PH_LOW_DROP;
      end
      default: begin
        enable_pin = 1'b0;
        if (ring_fill != 0) ring_fill--;
        pop_slot = pop_slot + 4'd1;
        nibble_phase = PH_HIGH;
      end
    endcase
  endtask

  task automatic predict_lcd(input lcd_request_t rq, output lcd_response_t rsp);
    logic [7:0] ddram_addr;
    rsp.status = ST_OK;
    case (rq.command)
      CMD_TICK: advance_bus();
      CMD_CHAR: rsp.status = queue_lcd_word({1'b1, rq.data_byte});
      CMD_RAW:  rsp.status = queue_lcd_word({1'b0, rq.data_byte});
      default: begin
        // A zero-sized display rejects every move, as the compares show.
        if (rq.cursor_column < column_limit && rq.cursor_row < row_limit) begin
          ddram_addr = rq.cursor_column;
          if (rq.cursor_row == 8'd1) ddram_addr = ddram_addr + line2_offset;
          rsp.status = queue_lcd_word({1'b0, 8'h80 | ddram_addr});
        end else begin
          rsp.status = ST_RANGE;
        end
      end
    endcase
    rsp.pin_rs = rs_pin;
    rsp.pin_data = data_pins;
    rsp.pin_enable = enable_pin;
    rsp.words_pending = ring_fill[4:0];
    if (ring_fill > peak_fill) peak_fill = ring_fill;
  endtask

  // ---------------------------------------------------------------------
  // Input driver. A word counts as taken at the edge where in_tvalid and
  // in_tready are both high; the prediction is made right there so that
  // it follows exactly the order in which the block sees the requests.
  // A new word is only put up once the previous one has been taken.
  // ---------------------------------------------------------------------
  lcd_request_t offered;
  lcd_response_t predicted;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_lcd(offered, predicted);
        pending_responses.push_back(predicted);
        requests_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_queue.size() != 0 &&
            (steady_flow || $urandom_range(0, 99) >= GAP_PCT)) begin
          offered = request_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= offered.command;
          in_tdata <= {offered.cursor_row, offered.cursor_column, offered.data_byte};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor. Each result word taken is compared field by field
  // with the oldest prediction; out_tready is re-rolled every cycle.
  // ---------------------------------------------------------------------
  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want,
               got);
      errors++;
    end
  endfunction

  lcd_response_t observed;
  lcd_response_t oldest;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        observed.status = out_tdata[1:0];
        observed.pin_rs = out_tdata[2];
        observed.pin_data = out_tdata[6:3];
        observed.pin_enable = out_tdata[7];
        observed.words_pending = out_tdata[12:8];
        responses_seen++;
        if (pending_responses.size() == 0) begin
          $display("%0t ns: result word with nothing expected, actual %h", $time,
                   observed);
          errors++;
        end else begin
          oldest = pending_responses.pop_front();
          status_tally[oldest.status]++;
          check_field("status", oldest.status, observed.status);
          check_field("pin_rs", oldest.pin_rs, observed.pin_rs);
          check_field("pin_data", oldest.pin_data, observed.pin_data);
          check_field("pin_enable", oldest.pin_enable, observed.pin_enable);
          check_field("words_pending", oldest.words_pending, observed.words_pending);
        end
      end
      out_tready <= steady_flow || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic lcd_request_t pack_request(input logic [1:0] cmd,
                                                input logic [7:0] byte_val,
                                                input logic [7:0] col,
                                                input logic [7:0] row);
    lcd_request_t rq;
    rq.command = cmd;
    rq.data_byte = byte_val;
    rq.cursor_column = col;
    rq.cursor_row = row;
    return rq;
  endfunction

  // Push-heavy mixes fill the ring until it reports busy, tick-heavy ones
  // drain it and run ticks on an empty ring. Most cursor moves take coordinates
  // from zero up to the limit inclusive, the rest from the whole byte range.
  function automatic lcd_request_t random_request(input int unsigned push_pct);
    lcd_request_t rq;
    rq = pack_request(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 99) < push_pct) begin
      case ($urandom_range(0, 2))
        0: rq.command = CMD_CHAR;
        1: rq.command = CMD_RAW;
        default: rq.command = CMD_CURSOR;
      endcase
      if (rq.command == CMD_CURSOR && $urandom_range(0, 99) < 80) begin
        rq.cursor_column = 8'($urandom_range(0, column_limit));
        rq.cursor_row = 8'($urandom_range(0, row_limit));
      end
    end
    return rq;
  endfunction

  // Registers change only while the block has nothing in flight. The
  // shadow copy takes the same value at the same moment.
  task automatic write_display_regs(input logic [6:0] cols, input logic [2:0] rows,
                                    input logic [6:0] offs);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_wdata <= {4'd0, rows};
    @(posedge clk);
    cfg_index <= REG_OFFSET;
    cfg_wdata <= offs;
    @(posedge clk);
    cfg_we <= 1'b0;
    column_limit = cols;
    row_limit = rows;
    line2_offset = offs;
  endtask

  // The queues and in_tvalid are looked at on the falling edge, where the
  // driver and the monitor have both finished their work for the cycle.
  task automatic wait_for_quiet();
    while (request_queue.size() != 0 || in_tvalid || pending_responses.size() != 0)
      @(negedge clk);
    // Let the sequencer finish its last word before anything else moves.
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence: reset, a directed opening at the reset settings, then
  // blocks of random words, the first two at the reset settings and each
  // later one under its own register setting.
  int unsigned push_mix;
  int unsigned drain_guard;

  initial begin
    for (int s = 0; s < 4; s++) status_tally[s] = 0;
    reset_shadow();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. The ring starts with seven words; in-range moves,
    // both RS kinds and extreme bytes bring it to sixteen, after which
    // pushes report busy while a bad position still reports out of range.
    request_queue.push_back(pack_request(CMD_CURSOR, 8'h00, 8'd15, 8'd0));
    request_queue.push_back(pack_request(CMD_CURSOR, 8'h00, 8'd16, 8'd0));
    request_queue.push_back(pack_request(CMD_CURSOR, 8'h00, 8'd0, 8'd1));
    request_queue.push_back(pack_request(CMD_CURSOR, 8'h00, 8'd0, 8'd2));
    request_queue.push_back(pack_request(CMD_CURSOR, 8'hFF, 8'd255, 8'd255));
    request_queue.push_back(pack_request(CMD_CURSOR, 8'h00, 8'd3, 8'd1));
    request_queue.push_back(pack_request(CMD_CHAR, 8'h00, 8'h00, 8'h00));
    request_queue.push_back(pack_request(CMD_CHAR, 8'hFF, 8'hFF, 8'hFF));
    request_queue.push_back(pack_request(CMD_RAW, 8'h00, 8'h00, 8'h00));
    request_queue.push_back(pack_request(CMD_RAW, 8'hFF, 8'h00, 8'h00));
    request_queue.push_back(pack_request(CMD_CHAR, 8'h5A, 8'h00, 8'h00));
    request_queue.push_back(pack_request(CMD_RAW, 8'hA5, 8'h00, 8'h00));
    request_queue.push_back(pack_request(CMD_CHAR, 8'h33, 8'h00, 8'h00));
    request_queue.push_back(pack_request(CMD_CURSOR, 8'h00, 8'd1, 8'd0));
    request_queue.push_back(pack_request(CMD_CURSOR, 8'h00, 8'd200, 8'd0));
    for (int i = 0; i < 8; i++)
      request_queue.push_back(pack_request(CMD_TICK, 8'h00, 8'h00, 8'h00));
    wait_for_quiet();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      steady_flow = 1'b0;
      case (blk)
        // Reset settings: first drain the ring, then flood it.
        0: push_mix = 3;
        1: push_mix = 60;
        2: begin
          write_display_regs(7'd64, 3'd4, 7'd127);
          push_mix = 25;
        end
        3: begin
          write_display_regs(7'd1, 3'd1, 7'd0);
          push_mix = 40;
        end
        4: begin
          // A display of zero size rejects every cursor move.
          write_display_regs(7'd0, 3'd0, 7'd0);
          push_mix = 30;
        end
        5: begin
          // Register ceilings, with no gaps on either side.
          write_display_regs(7'd127, 3'd7, 7'd127);
          push_mix = 50;
          steady_flow = 1'b1;
        end
        default: begin
          write_display_regs(7'($urandom_range(1, 64)), 3'($urandom_range(1, 4)),
                             7'($urandom_range(0, 127)));
          case ($urandom_range(0, 3))
            0: push_mix = 5;
            1: push_mix = 20;
            2: push_mix = 25;
            default: push_mix = 60;
          endcase
        end
      endcase
      for (int i = 0; i < BLOCK_ITEMS; i++)
        request_queue.push_back(random_request(push_mix));
      while (request_queue.size() != 0 || in_tvalid) @(negedge clk);
      drain_guard = 0;
      while (pending_responses.size() != 0 && drain_guard < 2000) begin
        @(negedge clk);
        drain_guard++;
      end
      if (pending_responses.size() != 0) begin
        $display("%0t ns: %0d result words never arrived", $time,
                 pending_responses.size());
        errors++;
        pending_responses.delete();
      end
      repeat (8) @(posedge clk);
    end

    // Any result word that still shows up here is flagged by the monitor.
    repeat (20) @(posedge clk);
    $display("Covered %0d requests, %0d results: %0d ok, %0d busy, %0d out of range.",
             requests_taken, responses_seen, status_tally[ST_OK],
             status_tally[ST_BUSY], status_tally[ST_RANGE]);
    $display("Ticks on an empty ring: %0d, highest ring fill: %0d, errors: %0d.",
             idle_ticks, peak_fill, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
